// File: src/pdsr_pkg.sv
package pdsr_pkg;

	// input beat kinds (tuser)
	localparam logic OP_STEP    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// configuration register indexes
	localparam logic [2:0] REG_KP       = 3'd0;
	localparam logic [2:0] REG_KI       = 3'd1;
	localparam logic [2:0] REG_KD       = 3'd2;
	localparam logic [2:0] REG_DEADBAND = 3'd3;
	localparam logic [2:0] REG_SIGN_EN  = 3'd4;

	// dt = 0.01 s: 5243 / 2^19 for the integral, 100 for the derivative
	localparam logic signed [13:0] INC_MULT   = 14'sd5243;
	localparam int                 INC_SHIFT  = 19;
	localparam logic signed [7:0]  DERIV_MULT = 8'sd100;

	localparam int INTEG_W = 48;
	localparam int DERIV_W = 40;
	localparam int ERR_W   = 32;

	typedef logic signed [INTEG_W-1:0] integ_t;
	typedef logic signed [DERIV_W-1:0] deriv_t;
	typedef logic signed [ERR_W-1:0]   err_t;

endpackage

// File: src/pid_deadband_sign_reset_core.sv
// channel   | dir | handshake                   | payload
// ----------+-----+-----------------------------+----------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready | tdata: error_value; tuser: operation
// m_axis    | out | m_axis_tvalid/m_axis_tready | tdata: drive
// cfg       | in  | cfg_valid/cfg_ready         | cfg_addr: register index; cfg_data: value
//
// One beat per cycle sustained unless the output stalls; a control step goes through the
// input reg, state update, products, partial sums and output reg. Restart beats give no result.
// The integral and previous-error state close their loop inside the second stage.
// A stalled output register freezes the whole pipe and drops s_axis_tready.
// arst_n clears the state, the gains and all valid bits.
module pid_deadband_sign_reset_core
	import pdsr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] error_value
	input  logic        s_axis_tuser,   // [0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] drive
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_data
);

	logic               en;
	err_t               kp_q, ki_q, kd_q;
	logic [30:0]        deadband_q;
	logic               sign_en_q;
	integ_t             integ_q;
	err_t               prev_q;

	logic               v_s1, op_s1;
	err_t               err_s1;
	logic               v_s2;
	err_t               err_s2;
	integ_t             integ_s2;
	deriv_t             deriv_s2;
	logic               v_s3;
	logic signed [63:0] p_kp_s3, p_kih_s3;
	logic signed [48:0] p_kil_s3, p_kdl_s3;
	logic signed [55:0] p_kdh_s3;
	logic               v_s4;
	logic signed [64:0] hsum_s4;
	logic signed [65:0] lsum_s4;
	logic               out_valid_q;
	logic [31:0]        out_data_q;

	logic [31:0]        mag;
	logic               over_band, sign_flip;
	logic signed [45:0] inc_prod;
	logic signed [26:0] inc;
	logic signed [48:0] integ_sum;
	integ_t             integ_sat, integ_nxt;
	logic signed [32:0] diff;
	logic signed [40:0] deriv_prod;
	deriv_t             deriv_sat;
	logic signed [31:0] ih;
	logic signed [16:0] il, dl;
	logic signed [23:0] dh;
	logic signed [65:0] total;
	logic [31:0]        drive_sat;

	assign en            = !out_valid_q || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q       <= '0;
			ki_q       <= '0;
			kd_q       <= '0;
			deadband_q <= '0;
			sign_en_q  <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				REG_KP:       kp_q       <= cfg_data;
				REG_KI:       ki_q       <= cfg_data;
				REG_KD:       kd_q       <= cfg_data;
				REG_DEADBAND: deadband_q <= cfg_data[30:0];
				REG_SIGN_EN:  sign_en_q  <= cfg_data[0];
				default:      ;
			endcase
		end
	end

	// stage 1 -> 2: integral and derivative, state update
	always_comb begin
		mag       = err_s1[31] ? 32'(-err_s1) : 32'(err_s1);
		over_band = mag > {1'b0, deadband_q};
		sign_flip = sign_en_q && (err_s1[31] != prev_q[31]);
		inc_prod  = err_s1 * INC_MULT;
		inc       = inc_prod[45:INC_SHIFT];
		integ_sum = 49'(integ_q) + 49'(inc);
		if (integ_sum[48] != integ_sum[47])
			integ_sat = integ_sum[48] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
		else
			integ_sat = integ_sum[47:0];
		if (op_s1 == OP_RESTART || over_band || sign_flip)
			integ_nxt = '0;
		else
			integ_nxt = integ_sat;
		diff       = 33'(err_s1) - 33'(prev_q);
		deriv_prod = diff * DERIV_MULT;
		if (deriv_prod[40] != deriv_prod[39])
			deriv_sat = deriv_prod[40] ? {1'b1, {(DERIV_W-1){1'b0}}} : {1'b0, {(DERIV_W-1){1'b1}}};
		else
			deriv_sat = deriv_prod[39:0];
	end

	// stage 2 -> 3: split the wide operands so each product stays within 32x32
	always_comb begin
		ih = integ_s2[47:16];
		il = $signed({1'b0, integ_s2[15:0]});
		dh = deriv_s2[39:16];
		dl = $signed({1'b0, deriv_s2[15:0]});
	end

	// stage 4 -> out: floor(sum / 2^16), then clamp to 32 bits
	always_comb begin
		total = 66'(hsum_s4) + (lsum_s4 >>> 16);
		if (total[65:31] != {35{total[31]}})
			drive_sat = total[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
		else
			drive_sat = total[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q     <= '0;
			prev_q      <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= s_axis_tvalid;
			v_s2        <= v_s1 && op_s1 == OP_STEP;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
			if (v_s1) begin
				integ_q <= integ_nxt;
				prev_q  <= err_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1      <= s_axis_tuser;
			err_s1     <= s_axis_tdata;
			err_s2     <= err_s1;
			integ_s2   <= integ_nxt;
			deriv_s2   <= deriv_sat;
			p_kp_s3    <= kp_q * err_s2;
			p_kih_s3   <= ki_q * ih;
			p_kil_s3   <= ki_q * il;
			p_kdh_s3   <= kd_q * dh;
			p_kdl_s3   <= kd_q * dl;
			hsum_s4    <= 65'(p_kih_s3) + 65'(p_kdh_s3);
			lsum_s4    <= 66'(p_kp_s3) + 66'(p_kil_s3) + 66'(p_kdl_s3);
			out_data_q <= drive_sat;
		end
	end

endmodule

// File: src/pdsr_checker.sv
module pdsr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [31:0] s_axis_tdata,
	input logic        s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// input side only stalls when the output register is full and blocked
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("input ready does not follow output occupancy");

	// a fresh result only appears after the pipe advanced
	a_rise_needs_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tready))
		else $error("result appeared while pipe was frozen");

	// an offered input beat carries known kind and data
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid |-> !$isunknown({s_axis_tuser, s_axis_tdata}))
		else $error("input beat carries unknown bits");

	// a result beat carries known data
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !$isunknown(m_axis_tdata))
		else $error("result beat carries unknown bits");

endmodule

bind pid_deadband_sign_reset_core pdsr_checker u_pdsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// File: sim/tb_pid_deadband_sign_reset_core.sv
`timescale 1ns / 1ps

module tb_pid_deadband_sign_reset_core;
	import pdsr_pkg::*;

	localparam int LIMIT       = 400000;
	localparam int SETTLE      = 12;   // pipe depth plus margin for a trailing restart
	localparam int N_PHASES    = 8;
	localparam int PHASE_ITEMS = 80;
	localparam int PLAN_LEN    = 36;

	localparam logic [2:0] REG_SPARE   = 3'd6;
	localparam logic [2:0] REG_IDX_MAX = 3'd7;
	localparam logic [2:0] ITEM_STEP    = {2'b00, OP_STEP};
	localparam logic [2:0] ITEM_RESTART = {2'b00, OP_RESTART};

	localparam err_t ERR_MAX = 32'sh7FFF_FFFF;
	localparam err_t ERR_MIN = 32'sh8000_0000;
	localparam logic signed [63:0] INTEG_TOP = (64'sd1 <<< (INTEG_W - 1)) - 1;
	localparam logic signed [63:0] INTEG_BOT = -INTEG_TOP - 1;
	localparam logic signed [63:0] DERIV_TOP = (64'sd1 <<< (DERIV_W - 1)) - 1;
	localparam logic signed [63:0] DERIV_BOT = -DERIV_TOP - 1;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  code;    // beat kind or register index
		logic [31:0] value;
		logic        known;   // drive below is typed in
		logic [31:0] drive;
	} stim_row_t;

	localparam stim_row_t PLAN [PLAN_LEN] = '{
		// gains are zero after reset
		'{ROW_ITEM, ITEM_STEP,    32'h7FFF_FFFF, 1'b1, 32'h0000_0000},
		'{ROW_ITEM, ITEM_STEP,    32'h8000_0000, 1'b1, 32'h0000_0000},
		'{ROW_ITEM, ITEM_RESTART, 32'h0000_0005, 1'b0, 32'h0},
		'{ROW_ITEM, ITEM_STEP,    32'h0000_0000, 1'b1, 32'h0000_0000},
		// Kp = 1.0, unused data bits set
		'{ROW_CFG,  REG_KP,       32'h0001_0000, 1'b0, 32'h0},
		'{ROW_CFG,  REG_DEADBAND, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{ROW_CFG,  REG_SIGN_EN,  32'h0000_0003, 1'b0, 32'h0},
		'{ROW_CFG,  REG_SPARE,    32'h1234_5678, 1'b0, 32'h0},
		'{ROW_ITEM, ITEM_STEP,    32'h0001_0000, 1'b1, 32'h0001_0000},
		'{ROW_ITEM, ITEM_STEP,    32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
		'{ROW_ITEM, ITEM_STEP,    32'h8000_0000, 1'b1, 32'h8000_0000},
		'{ROW_ITEM, ITEM_STEP,    32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
		// saturation both ways
		'{ROW_CFG,  REG_KP,       32'h7FFF_FFFF, 1'b0, 32'h0},
		'{ROW_ITEM, ITEM_STEP,    32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
		'{ROW_ITEM, ITEM_STEP,    32'h8000_0000, 1'b1, 32'h8000_0000},
		'{ROW_CFG,  REG_KP,       32'h8000_0000, 1'b0, 32'h0},
		'{ROW_ITEM, ITEM_STEP,    32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
		'{ROW_ITEM, ITEM_STEP,    32'h8000_0000, 1'b1, 32'h7FFF_FFFF},
		// integral clearing rules
		'{ROW_CFG,  REG_KP,       32'h0000_0000, 1'b0, 32'h0},
		'{ROW_CFG,  REG_KI,       32'h7FFF_FFFF, 1'b0, 32'h0},
		'{ROW_CFG,  REG_KD,       32'h8000_0000, 1'b0, 32'h0},
		'{ROW_CFG,  REG_DEADBAND, 32'h0001_0000, 1'b0, 32'h0},
		'{ROW_ITEM, ITEM_RESTART, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{ROW_ITEM, ITEM_STEP,    32'h0000_0000, 1'b0, 32'h0},  // zero is positive
		'{ROW_ITEM, ITEM_STEP,    32'h0001_0000, 1'b0, 32'h0},  // on the deadband
		'{ROW_ITEM, ITEM_STEP,    32'h0001_0001, 1'b0, 32'h0},  // just past it
		'{ROW_ITEM, ITEM_STEP,    32'h0000_8000, 1'b0, 32'h0},
		'{ROW_ITEM, ITEM_STEP,    32'hFFFF_8000, 1'b0, 32'h0},  // sign flip
		'{ROW_CFG,  REG_SIGN_EN,  32'hFFFF_FFFE, 1'b0, 32'h0},
		'{ROW_ITEM, ITEM_STEP,    32'hFFFF_0000, 1'b0, 32'h0},
		'{ROW_ITEM, ITEM_STEP,    32'h0000_1000, 1'b0, 32'h0},
		'{ROW_CFG,  REG_DEADBAND, 32'h7FFF_FFFF, 1'b0, 32'h0},
		'{ROW_ITEM, ITEM_STEP,    32'h8000_0000, 1'b0, 32'h0},  // |min| exceeds max band
		'{ROW_ITEM, ITEM_RESTART, 32'h7FFF_FFFF, 1'b0, 32'h0},
		'{ROW_ITEM, ITEM_STEP,    32'h8000_0000, 1'b0, 32'h0},
		'{ROW_ITEM, ITEM_STEP,    32'h0000_0000, 1'b0, 32'h0}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_addr;
	logic [31:0] cfg_data;

	// controller mirror
	err_t        kp, ki, kd;
	logic [30:0] band;
	logic        sign_clr;
	integ_t      integ;
	err_t        last_err;

	err_t drive_q[$];
	bit   src_gaps, sink_gaps;
	int   mismatches, drives_checked, steps_sent, restarts_sent, reg_writes, cycles;

	pid_deadband_sign_reset_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// one control step: integral rules, derivative, exact sum floored by 2^16
	function automatic err_t pid_step(input err_t e);
		logic signed [63:0] e_w, prev_w, mag, acc, dif;
		logic signed [95:0] sum;
		deriv_t             d;
		e_w    = e;
		prev_w = last_err;
		mag    = (e_w < 0) ? -e_w : e_w;
		if (mag > {33'd0, band}) begin
			integ = '0;
		end else if (sign_clr && (e[ERR_W-1] != last_err[ERR_W-1])) begin
			integ = '0;
		end else begin
			acc = integ + ((e_w * INC_MULT) >>> INC_SHIFT);
			if (acc > INTEG_TOP) acc = INTEG_TOP;
			if (acc < INTEG_BOT) acc = INTEG_BOT;
			integ = acc[INTEG_W-1:0];
		end
		dif = (e_w - prev_w) * DERIV_MULT;
		if (dif > DERIV_TOP) dif = DERIV_TOP;
		if (dif < DERIV_BOT) dif = DERIV_BOT;
		d = dif[DERIV_W-1:0];
		last_err = e;
		sum = kp * e + ki * integ + kd * d;
		sum = sum >>> 16;
		if (sum > 96'sd2147483647) return ERR_MAX;
		if (sum < -96'sd2147483648) return ERR_MIN;
		return sum[31:0];
	endfunction

	function automatic err_t pick_gain(input int phase);
		err_t s;
		if (phase == 0) return ERR_MAX;
		if (phase == 1) return ERR_MIN;
		s = $urandom_range(0, 32'h0004_0000);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return ERR_MAX;
			2: return ERR_MIN;
			3: return $urandom_range(0, 1) ? s : -s;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] pick_band(input int phase);
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: v = '0;
			1: v = 32'h7FFF_FFFF;
			2: v = $urandom_range(0, 32'h0002_0000);
			default: v = $urandom();
		endcase
		if (phase == 0) v = 32'h7FFF_FFFF;
		if (phase == 1) v = '0;
		v[31] = $urandom_range(0, 1);   // ignored bit
		return v;
	endfunction

	function automatic err_t pick_error();
		err_t s;
		case ($urandom_range(0, 9)) inside
			[0:3]: begin
				s = $urandom_range(0, 32'h0003_0000);
				return $urandom_range(0, 1) ? s : -s;
			end
			[4:5]: return $urandom();
			6: begin
				case ($urandom_range(0, 3))
					0: return ERR_MAX;
					1: return ERR_MIN;
					2: return '0;
					default: return -32'sd1;
				endcase
			end
			7: return -last_err;
			8: begin
				// straddle the deadband edge
				s = {1'b0, band} + $urandom_range(0, 2) - 1;
				return $urandom_range(0, 1) ? s : -s;
			end
			default: return last_err + $urandom_range(0, 64) - 32;
		endcase
	endfunction

	task automatic send_item(input logic op, input err_t e, input logic known,
			input err_t typed);
		int   gap;
		err_t want;
		gap = src_gaps ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= e;
		do @(posedge clk); while (!s_axis_tready);
		if (op == OP_RESTART) begin
			last_err = e;
			integ    = '0;
			restarts_sent++;
		end else begin
			want = pid_step(e);
			drive_q.push_back(known ? typed : want);
			steps_sent++;
		end
	endtask

	// leaves cfg_valid high; caller drops it once the group is written
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_KP:       kp = val;
			REG_KI:       ki = val;
			REG_KD:       kd = val;
			REG_DEADBAND: band = val[30:0];
			REG_SIGN_EN:  sign_clr = val[0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// output side backpressure
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = sink_gaps ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin : drive_check
		err_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (drive_q.size() == 0) begin
				$error("drive: no beat expected, got %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = drive_q.pop_front();
				if (m_axis_tdata !== want) begin
					$error("drive: expected %h, got %h", want, m_axis_tdata);
					mismatches++;
				end
				drives_checked++;
			end
		end
	end

	initial begin
		int        n;
		stim_row_t row;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = OP_STEP;
		cfg_valid     = 1'b0;
		cfg_addr      = REG_KP;
		cfg_data      = '0;
		kp = '0; ki = '0; kd = '0; band = '0; sign_clr = 1'b0;
		integ = '0; last_err = '0;
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < PLAN_LEN; r++) begin
			row = PLAN[r];
			if (row.kind == ROW_CFG) begin
				if (s_axis_tvalid) settle();
				write_reg(row.code, row.value);
			end else begin
				if (cfg_valid) cfg_valid <= 1'b0;
				send_item(row.code[0], row.value, row.known, row.drive);
			end
		end

		for (int p = 0; p < N_PHASES; p++) begin
			settle();
			write_reg(REG_KP, pick_gain(p));
			write_reg(REG_KI, pick_gain(p));
			write_reg(REG_KD, pick_gain(p));
			write_reg(REG_DEADBAND, pick_band(p));
			write_reg(REG_SIGN_EN, (p < 2) ? 32'(p == 0) : $urandom());
			if ($urandom_range(0, 2) == 0)
				write_reg(3'($urandom_range(REG_SIGN_EN + 1, REG_IDX_MAX)), $urandom());
			cfg_valid <= 1'b0;
			src_gaps  = (p % 3) != 2;
			sink_gaps = (p % 4) != 3;
			for (n = 0; n < PHASE_ITEMS; n++)
				send_item(($urandom_range(0, 11) == 0) ? OP_RESTART : OP_STEP,
					pick_error(), 1'b0, '0);
		end
		settle();

		$display("%0d control steps and %0d restarts sent, %0d drive beats checked",
			steps_sent, restarts_sent, drives_checked);
		$display("%0d register writes: directed table plus %0d random gain phases, %s",
			reg_writes, N_PHASES, "with and without stalls");
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: sim.f
src/pdsr_pkg.sv
src/pid_deadband_sign_reset_core.sv
src/pdsr_checker.sv
sim/tb_pid_deadband_sign_reset_core.sv
